>>> design/mdm_pkg.sv
package mdm_pkg;

    localparam int CHANNELS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4096;
    localparam int COUNT_BITS_DEF  = 24;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_TICK  = 3'd2;
    localparam logic [2:0] CMD_FETCH = 3'd3;
    localparam logic [2:0] CMD_PULL  = 3'd4;

    localparam logic [15:0] RATE_REG     = 16'h03c0;
    localparam logic [31:0] CTRL_COUNT   = 32'h00ffffff;
    localparam int          CTRL_REPLACE = 28;
    localparam int          CTRL_STEREO  = 29;

    localparam logic [1:0] SLOT_ADDR = 2'd0;
    localparam logic [1:0] SLOT_CTRL = 2'd1;

    // input request: command, bus_address, write_data, channel, fetch_data
    localparam int IN_BITS  = 88;
    // result: read_data, access_error, fetch_request, fetch_address, left, right
    localparam int OUT_BITS = 96;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POP  = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

>>> design/mdm_queue_ram.sv
module mdm_queue_ram #(
    parameter int AW = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/multichannel_audio_dma_mixer.sv
// From acceptance, register read, write, tick and stereo fetch pass through ACC
// to DONE (m_tvalid); a mono fetch also passes through POP (two queue writes);
// a sample pull loops in POP with one queue read and one add per channel.
// One request at a time; s_tready is low until the result is taken and the
// state returns to IDLE.
// aresetn (synchronous, active low) clears all descriptors and queue pointers.
module multichannel_audio_dma_mixer #(
    parameter int CHANNELS    = mdm_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = mdm_pkg::QUEUE_DEPTH_DEF,
    parameter int COUNT_BITS  = mdm_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], bus_address[18:3], write_data[50:19], channel[54:51],
    // fetch_data[86:55]
    input  logic [mdm_pkg::IN_BITS-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[15:0], access_error[16], fetch_request[17], fetch_address[49:18],
    // left_sum[69:50], right_sum[89:70]
    output logic [mdm_pkg::OUT_BITS-1:0] m_tdata
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = 4 + QW;
    localparam int FW = QW + 1;

    logic [31:0]          latched_reg [CHANNELS];
    logic [31:0]          cur_addr_reg [CHANNELS];
    logic [COUNT_BITS-1:0] cur_cnt_reg [CHANNELS];
    logic [CHANNELS-1:0]  cur_st_reg;
    logic [31:0]          nxt_addr_reg [CHANNELS];
    logic [COUNT_BITS-1:0] nxt_cnt_reg [CHANNELS];
    logic [CHANNELS-1:0]  nxt_st_reg;
    logic [CHANNELS-1:0]  pend_reg;
    logic [QW-1:0]        head_reg [CHANNELS];
    logic [FW-1:0]        fill_reg [CHANNELS];

    mdm_pkg::state_t state_reg;
    logic [mdm_pkg::IN_BITS-1:0] req_reg;
    logic [15:0] rdata_reg;
    logic        err_reg, freq_reg;
    logic [31:0] faddr_reg;
    logic signed [19:0] lsum_reg, rsum_reg;
    logic [CW:0] idx_reg;
    logic        popped_reg;
    logic        second_reg;
    logic [31:0] second_data_reg;
    logic [QW-1:0] second_pos_reg;

    logic [2:0]  cmd;
    logic [15:0] baddr;
    logic [31:0] wdata, fdata;
    logic [3:0]  chn;
    assign cmd   = req_reg[2:0];
    assign baddr = req_reg[18:3];
    assign wdata = req_reg[50:19];
    assign chn   = req_reg[54:51];
    assign fdata = req_reg[86:55];

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wd, rd;

    mdm_queue_ram #(.AW(AW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wd), .raddr(raddr), .rdata(rd)
    );

    logic [CW-1:0] ic;
    assign ic = idx_reg[CW-1:0];
    assign raddr = {4'(ic), head_reg[ic]};

    assign s_tready = (state_reg == mdm_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == mdm_pkg::ST_DONE);
    assign m_tdata  = {6'd0, rsum_reg, lsum_reg, faddr_reg, freq_reg, err_reg, rdata_reg};

    logic chn_ok;
    logic [CW-1:0] ch;
    assign chn_ok = ({28'd0, chn} < CHANNELS);
    assign ch = CW'(chn);
    logic [FW:0] need_fill;
    logic room;
    assign need_fill = {1'b0, fill_reg[ch]} + (cur_st_reg[ch] ? (FW+1)'(1) : (FW+1)'(2));
    assign room = (need_fill <= (FW+1)'(QUEUE_DEPTH));
    logic [QW-1:0] tail;
    assign tail = QW'({1'b0, head_reg[ch]} + fill_reg[ch]);

    logic [11:0] rc;
    logic [1:0]  slot;
    assign rc = baddr[15:4];
    assign slot = baddr[3:2];
    localparam int CTRL_STEREO_B = mdm_pkg::CTRL_STEREO;
    logic [COUNT_BITS-1:0] cnt_w;
    logic [31:0] cnt_raw;
    assign cnt_raw = wdata[CTRL_STEREO_B] ? (wdata & mdm_pkg::CTRL_COUNT)
                                          : ((wdata & mdm_pkg::CTRL_COUNT) >> 1);
    assign cnt_w = COUNT_BITS'(cnt_raw);

    logic [CHANNELS-1:0] busy;
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) busy[i] = (nxt_cnt_reg[i] != '0);
    end

    always_comb begin
        we = 1'b0;
        waddr = {4'(ch), tail};
        wd = fdata;
        if (state_reg == mdm_pkg::ST_POP && cmd == mdm_pkg::CMD_FETCH) begin
            if (second_reg) begin
                we = 1'b1;
                waddr = {4'(ch), second_pos_reg};
                wd = second_data_reg;
            end
        end else if (state_reg == mdm_pkg::ST_ACC && cmd == mdm_pkg::CMD_FETCH) begin
            if (chn_ok && pend_reg[ch] && cur_cnt_reg[ch] != '0 && room) begin
                we = 1'b1;
                wd = cur_st_reg[ch] ? fdata : {fdata[15:0], fdata[15:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mdm_pkg::ST_IDLE;
            cur_st_reg <= '0;
            nxt_st_reg <= '0;
            pend_reg <= '0;
            second_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                latched_reg[i] <= '0;
                cur_addr_reg[i] <= '0;
                cur_cnt_reg[i] <= '0;
                nxt_addr_reg[i] <= '0;
                nxt_cnt_reg[i] <= '0;
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                mdm_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg <= s_tdata;
                        state_reg <= mdm_pkg::ST_ACC;
                        rdata_reg <= '0;
                        err_reg <= 1'b0;
                        freq_reg <= 1'b0;
                        faddr_reg <= '0;
                        lsum_reg <= '0;
                        rsum_reg <= '0;
                        idx_reg <= '0;
                        popped_reg <= 1'b0;
                    end
                end
                mdm_pkg::ST_ACC: begin
                    state_reg <= mdm_pkg::ST_DONE;
                    case (cmd)
                        mdm_pkg::CMD_WRITE: begin
                            if (baddr != mdm_pkg::RATE_REG) begin
                                if ({20'd0, rc} >= CHANNELS) begin
                                    err_reg <= 1'b1;
                                end else if (slot == mdm_pkg::SLOT_ADDR) begin
                                    latched_reg[CW'(rc)] <= wdata;
                                end else if (slot == mdm_pkg::SLOT_CTRL) begin
                                    if (wdata[mdm_pkg::CTRL_REPLACE]) begin
                                        cur_addr_reg[CW'(rc)] <= latched_reg[CW'(rc)];
                                        cur_cnt_reg[CW'(rc)] <= cnt_w;
                                        cur_st_reg[CW'(rc)] <= wdata[CTRL_STEREO_B];
                                        nxt_addr_reg[CW'(rc)] <= '0;
                                        nxt_cnt_reg[CW'(rc)] <= '0;
                                        nxt_st_reg[CW'(rc)] <= 1'b0;
                                        pend_reg[CW'(rc)] <= 1'b0;
                                    end else begin
                                        nxt_addr_reg[CW'(rc)] <= latched_reg[CW'(rc)];
                                        nxt_cnt_reg[CW'(rc)] <= cnt_w;
                                        nxt_st_reg[CW'(rc)] <= wdata[CTRL_STEREO_B];
                                    end
                                end
                            end
                        end
                        mdm_pkg::CMD_READ: begin
                            if (baddr == mdm_pkg::RATE_REG) rdata_reg <= 16'(busy);
                            else err_reg <= 1'b1;
                        end
                        mdm_pkg::CMD_TICK: begin
                            if (chn_ok) begin
                                if (cur_cnt_reg[ch] != '0) begin
                                    if (room) begin
                                        freq_reg <= 1'b1;
                                        faddr_reg <= cur_addr_reg[ch];
                                        pend_reg[ch] <= 1'b1;
                                    end
                                end else begin
                                    cur_addr_reg[ch] <= nxt_addr_reg[ch];
                                    cur_cnt_reg[ch] <= nxt_cnt_reg[ch];
                                    cur_st_reg[ch] <= nxt_st_reg[ch];
                                    nxt_addr_reg[ch] <= '0;
                                    nxt_cnt_reg[ch] <= '0;
                                    nxt_st_reg[ch] <= 1'b0;
                                    pend_reg[ch] <= 1'b0;
                                end
                            end
                        end
                        mdm_pkg::CMD_FETCH: begin
                            if (chn_ok && pend_reg[ch] && cur_cnt_reg[ch] != '0 && room) begin
                                cur_addr_reg[ch] <= cur_addr_reg[ch] + 32'd4;
                                cur_cnt_reg[ch] <= cur_cnt_reg[ch] - 1'b1;
                                pend_reg[ch] <= 1'b0;
                                if (cur_st_reg[ch]) begin
                                    fill_reg[ch] <= fill_reg[ch] + 1'b1;
                                end else begin
                                    fill_reg[ch] <= fill_reg[ch] + FW'(2);
                                    second_reg <= 1'b1;
                                    second_data_reg <= {fdata[31:16], fdata[31:16]};
                                    second_pos_reg <= tail + 1'b1;
                                    state_reg <= mdm_pkg::ST_POP;
                                end
                            end
                        end
                        mdm_pkg::CMD_PULL: begin
                            // each channel takes a read step, then an add step
                            state_reg <= mdm_pkg::ST_POP;
                        end
                        default: ;
                    endcase
                end
                mdm_pkg::ST_POP: begin
                    if (cmd == mdm_pkg::CMD_FETCH) begin
                        second_reg <= 1'b0;
                        state_reg <= mdm_pkg::ST_DONE;
                    end else if (!popped_reg) begin
                        if (idx_reg == (CW+1)'(CHANNELS)) begin
                            state_reg <= mdm_pkg::ST_DONE;
                        end else begin
                            popped_reg <= 1'b1;
                        end
                    end else begin
                        popped_reg <= 1'b0;
                        if (fill_reg[ic] != '0) begin
                            lsum_reg <= lsum_reg + 20'(signed'(rd[15:0]));
                            rsum_reg <= rsum_reg + 20'(signed'(rd[31:16]));
                            head_reg[ic] <= head_reg[ic] + 1'b1;
                            fill_reg[ic] <= fill_reg[ic] - 1'b1;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                mdm_pkg::ST_DONE: begin
                    if (m_tready) state_reg <= mdm_pkg::ST_IDLE;
                end
                default: state_reg <= mdm_pkg::ST_IDLE;
            endcase
        end
    end
endmodule

>>> design/mdm_checker.sv
module mdm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("ready while result pending");

    a_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[17] |-> m_tdata[49:18] == 32'd0)
        else $error("fetch address without request");

    a_excl2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17] |-> !m_tdata[16] && m_tdata[15:0] == 16'd0)
        else $error("fetch request mixed with register result");
endmodule

bind multichannel_audio_dma_mixer mdm_checker u_mdm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
